// ----- src/epom_pkg.sv -----
// ----------------------------------------------------------------------------
// epom_pkg
// shared types and constants of the exact-price order matcher
// ----------------------------------------------------------------------------
`default_nettype none

package epom_pkg;

	localparam int BOOK_DEPTH = 32;
	localparam int IDX_W      = $clog2(BOOK_DEPTH);
	localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_TRADE   = 3'd0,
		KIND_RESTED  = 3'd1,
		KIND_FILLED  = 3'd2,
		KIND_DROPPED = 3'd3,
		KIND_FULL    = 3'd4
	} result_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic        side;
		logic [15:0] symbol_id;
		logic [31:0] price;
		logic [23:0] quantity;
		logic [31:0] stop_loss;
		logic [31:0] take_profit;
	} order_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [15:0]  trade_symbol;
		logic [31:0]  trade_price;
		logic [23:0]  trade_quantity;
		logic         last_result;
	} result_t;

	typedef struct packed {
		logic        side;
		logic [15:0] symbol;
		logic [31:0] price;
		logic [23:0] quantity;
	} entry_t;

	// book update command from the sequencer
	typedef struct packed {
		logic             upd;
		logic             rem;
		logic             app;
		logic [IDX_W-1:0] idx;
		logic [23:0]      qty;
		entry_t           app_entry;
	} book_cmd_t;

	typedef struct packed {
		logic        hit;
		logic [23:0] trade_qty;
		logic [23:0] order_rem;
		logic [23:0] entry_rem;
	} match_res_t;

endpackage

`default_nettype wire

// ----- src/epom_book.sv -----
// ----------------------------------------------------------------------------
// epom_book
// resting order store in arrival order, with removal by shifting up
// ----------------------------------------------------------------------------
`default_nettype none

module epom_book
	import epom_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire book_cmd_t        cmd,
	input  wire logic [IDX_W-1:0] rd_idx,
	output entry_t                rd_entry,
	output logic [CNT_W-1:0]      count
);

	entry_t           entries_q [BOOK_DEPTH];
	logic [CNT_W-1:0] count_q;

	assign rd_entry = entries_q[rd_idx];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.rem) begin
			count_q <= count_q - CNT_W'(1);
		end else if (cmd.app && (count_q < CNT_W'(BOOK_DEPTH))) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.rem && (IDX_W'(k) >= cmd.idx)) begin
				if (k < BOOK_DEPTH - 1) begin
					entries_q[k] <= entries_q[(k + 1) % BOOK_DEPTH];
				end
			end else if (cmd.upd && (IDX_W'(k) == cmd.idx)) begin
				entries_q[k].quantity <= cmd.qty;
			end else if (cmd.app && (CNT_W'(k) == count_q)) begin
				entries_q[k] <= cmd.app_entry;
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/epom_match_unit.sv -----
// ----------------------------------------------------------------------------
// epom_match_unit
// compares one resting entry with the order and sizes the fill
// ----------------------------------------------------------------------------
`default_nettype none

module epom_match_unit
	import epom_pkg::*;
(
	input  wire entry_t      entry,
	input  wire logic        side,
	input  wire logic [15:0] symbol,
	input  wire logic [31:0] price,
	input  wire logic [23:0] qty,
	output match_res_t       res
);

	logic [23:0] fill;

	assign fill = (entry.quantity < qty) ? entry.quantity : qty;

	always_comb begin
		res.hit       = (entry.side != side) && (entry.symbol == symbol)
			&& (entry.price == price);
		res.trade_qty = fill;
		res.order_rem = qty - fill;
		res.entry_rem = entry.quantity - fill;
	end

endmodule

`default_nettype wire

// ----- src/exact_price_order_matcher_core.sv -----
// ----------------------------------------------------------------------------
// exact_price_order_matcher_core
// fifo limit order book matching at exact price, one order per start
// ----------------------------------------------------------------------------
// An order is taken when start is high and busy is low. The sequencer then
// walks the book oldest first, one slot per cycle through a single compare
// and subtract unit; a fill that empties a slot removes it in the same cycle
// and the scan stays on that slot. Each trade, and then one status beat with
// last_result set, appears on result for exactly one cycle under strobe; the
// receiver must take every beat as it comes. The scan stops early once the
// order is filled; a new order may be started in the cycle the status beat
// is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module exact_price_order_matcher_core
	import epom_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire order_t order,
	output logic        busy,
	output logic        strobe,
	output result_t     result
);

	state_t           state_q, state_d;
	order_t           ord_q;
	logic [23:0]      qty_q;
	logic             drop_q;
	logic [CNT_W-1:0] i_q;
	logic             strobe_q;
	result_t          result_q;

	book_cmd_t        cmd;
	entry_t           entry;
	logic [CNT_W-1:0] count;
	match_res_t       mres;

	logic             accept;
	logic             risk;
	logic             active;
	logic             emit;
	result_t          res_d;

	epom_book u_book (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_idx   (i_q[IDX_W-1:0]),
		.rd_entry (entry),
		.count    (count)
	);

	epom_match_unit u_match (
		.entry  (entry),
		.side   (ord_q.side),
		.symbol (ord_q.symbol_id),
		.price  (ord_q.price),
		.qty    (qty_q),
		.res    (mres)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign risk   = order.side ? (order.price >= order.take_profit)
		: (order.price <= order.stop_loss);
	assign active = (i_q < count) && (qty_q != '0);
	assign strobe = strobe_q;
	assign result = result_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (!active) state_d = S_STATUS;
			end
			S_STATUS: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and book commands
	always_comb begin
		cmd                 = '0;
		cmd.idx             = i_q[IDX_W-1:0];
		cmd.qty             = mres.entry_rem;
		cmd.app_entry.side   = ord_q.side;
		cmd.app_entry.symbol = ord_q.symbol_id;
		cmd.app_entry.price  = ord_q.price;
		cmd.app_entry.quantity = qty_q;
		emit                = 1'b0;
		res_d.result_kind    = KIND_TRADE;
		res_d.trade_symbol   = ord_q.symbol_id;
		res_d.trade_price    = ord_q.price;
		res_d.trade_quantity = '0;
		res_d.last_result    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_SCAN: begin
				if (active && mres.hit) begin
					emit                 = 1'b1;
					res_d.trade_price    = entry.price;
					res_d.trade_quantity = mres.trade_qty;
					cmd.rem              = (mres.entry_rem == '0);
					cmd.upd              = (mres.entry_rem != '0);
				end
			end
			S_STATUS: begin
				emit              = 1'b1;
				res_d.last_result = 1'b1;
				if (drop_q) begin
					res_d.result_kind = KIND_DROPPED;
				end else if (qty_q == '0) begin
					res_d.result_kind = KIND_FILLED;
				end else if (count < CNT_W'(BOOK_DEPTH)) begin
					res_d.result_kind    = KIND_RESTED;
					res_d.trade_quantity = qty_q;
					cmd.app              = 1'b1;
				end else begin
					res_d.result_kind    = KIND_FULL;
					res_d.trade_quantity = qty_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (accept) begin
				i_q <= '0;
			end else if ((state_q == S_SCAN) && active
				&& !(mres.hit && (mres.entry_rem == '0))) begin
				i_q <= i_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) result_q <= res_d;
		if (accept) begin
			ord_q  <= order;
			qty_q  <= risk ? '0 : order.quantity;
			drop_q <= risk || (order.quantity == '0);
		end else if ((state_q == S_SCAN) && active && mres.hit) begin
			qty_q <= mres.order_rem;
		end
	end

endmodule

`default_nettype wire

// ----- src/epom_checker.sv -----
// ----------------------------------------------------------------------------
// epom_checker
// port-level checks on the matcher's result beats
// ----------------------------------------------------------------------------
`default_nettype none

module epom_checker
	import epom_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    strobe,
	input wire result_t result
);

	// an accepted order always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("order accepted but block not busy");

	// status beat ends the order, so the block is free by then
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result |-> !busy)
		else $error("status beat while still busy");

	a_trade_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_TRADE)
		|-> !result.last_result && (result.trade_quantity != '0))
		else $error("malformed trade beat");

	a_zero_qty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && ((result.result_kind == KIND_FILLED)
		|| (result.result_kind == KIND_DROPPED)) |-> (result.trade_quantity == '0))
		else $error("filled or dropped status carries a quantity");

	// beats only follow an order in progress or its immediate end
	a_beat_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without an order in progress");

endmodule

bind exact_price_order_matcher_core epom_checker u_epom_checker (.*);

`default_nettype wire
